@@ hdl/ntc_pkg.sv @@
// Shared types, codes and the float-syntax transition table of the number token classifier.
package ntc_pkg;

    // Result classes
    typedef enum logic [1:0] {
        TOK_INTEGER = 2'd0,
        TOK_FLOAT   = 2'd1,
        TOK_SYMBOL  = 2'd2
    } token_class_t;

    // Character classes seen by the float automaton
    typedef enum logic [2:0] {
        CLS_SIGN  = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_EXP   = 3'd2,
        CLS_POINT = 3'd3,
        CLS_OTHER = 3'd4
    } char_class_t;

    typedef logic [3:0] fs_state_t;

    localparam fs_state_t FS_START  = 4'd0;
    localparam fs_state_t FS_REJECT = 4'd10;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_EXP_LC  = 8'h65;
    localparam logic [7:0] CHAR_EXP_UC  = 8'h45;

    // Rows: sign, digit, exponent, point. Columns: current state 0..9.
    localparam fs_state_t FS_NEXT [0:3][0:9] = '{
        '{4'd1,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd8,  4'd10, 4'd10},
        '{4'd2,  4'd2,  4'd2,  4'd4,  4'd4,  4'd6,  4'd6,  4'd9,  4'd9,  4'd9 },
        '{4'd10, 4'd10, 4'd7,  4'd7,  4'd7,  4'd10, 4'd7,  4'd10, 4'd10, 4'd10},
        '{4'd5,  4'd5,  4'd3,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10}
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } char_item_t;

    typedef struct packed {
        token_class_t       token_class;
        logic signed [63:0] int_value;
    } result_item_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cls;
        if (c == CHAR_PLUS || c == CHAR_MINUS)
            cls = CLS_SIGN;
        else if (c >= CHAR_ZERO && c <= CHAR_NINE)
            cls = CLS_DIGIT;
        else if (c == CHAR_EXP_LC || c == CHAR_EXP_UC)
            cls = CLS_EXP;
        else if (c == CHAR_POINT)
            cls = CLS_POINT;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    function automatic fs_state_t float_step(input char_class_t cls, input fs_state_t st);
        fs_state_t nxt;
        if (st >= FS_REJECT || cls == CLS_OTHER)
            nxt = FS_REJECT;
        else
            nxt = FS_NEXT[cls[1:0]][st];
        return nxt;
    endfunction

    function automatic logic float_accept(input fs_state_t st);
        logic ok;
        case (st) inside
            4'd3, 4'd4, 4'd6, 4'd9: ok = 1'b1;
            default:                ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ hdl/number_token_classifier.sv @@
// Top level of the number token classifier: token state, classification and result buffering.
//
// Usage:
//   Characters of one atom token arrive on the char channel, one per transfer,
//   with last set on the final one. A transfer happens when char_valid is high
//   and char_stall is low. On the last character one result leaves on the
//   result channel: token_class (integer, float or symbol) and, for integers,
//   the signed decimal value wrapped to 64 bits.
//   The result is registered: it enters the output register, or the skid entry
//   while an older result is still held in the output register by stall.
//   Throughput: one character per cycle while char_stall is low; each
//   character's state update is a shift-add of the accumulator and one table step.
//   The accumulator holds the signed value directly: after a leading '-' each
//   digit is subtracted, so no negation is needed at the end of the token.
//   Result side: an output register plus one skid entry. While the receiver
//   stalls, characters keep flowing until the skid entry holds a second
//   result; only then does char_stall rise.
//   cfg_write loads float_enable from cfg_data; do so only while idle.
//   Reset clears the token state and both result entries; float_enable
//   returns to 1.
module number_token_classifier #(
    parameter int MAX_TOKEN_LEN = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  ntc_pkg::char_item_t  char_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ntc_pkg::result_item_t result_data,
    input  logic                 cfg_write,
    input  logic                 cfg_data
);
    import ntc_pkg::*;

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

    // Token state
    logic [CNT_W-1:0] count_reg, count_next;
    logic             negative_reg, negative_next;
    logic             nondigit_reg, nondigit_next;
    logic             digit_reg, digit_next;
    logic [63:0]      acc_reg, acc_next;
    fs_state_t        fstate_reg, fstate_next;
    logic             float_enable_reg;

    // Result buffering
    logic             out_valid_reg;
    result_item_t     out_data_reg;
    logic             skid_valid_reg;
    result_item_t     skid_data_reg;

    logic             char_fire;
    logic             take;
    logic             is_digit;
    logic [3:0]       digit;
    logic [63:0]      acc_times_ten;
    logic [63:0]      digit_term;
    logic [63:0]      upd_acc;
    logic             upd_negative;
    logic             upd_nondigit;
    logic             upd_digit;
    fs_state_t        upd_fstate;
    logic [CNT_W-1:0] upd_count;
    logic             new_result;
    result_item_t     result_next;
    logic             out_free;

    assign char_stall = skid_valid_reg;
    assign char_fire  = char_valid && !char_stall;
    assign take       = count_reg < CNT_W'(MAX_TOKEN_LEN);

    assign is_digit      = char_data.char_code >= CHAR_ZERO && char_data.char_code <= CHAR_NINE;
    assign digit         = 4'(char_data.char_code - CHAR_ZERO);
    assign acc_times_ten = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
    assign digit_term    = negative_reg ? (64'd0 - {60'd0, digit}) : {60'd0, digit};

    // One character step; characters past the limit leave the state as is
    always_comb
    begin
        upd_count    = count_reg;
        upd_negative = negative_reg;
        upd_nondigit = nondigit_reg;
        upd_digit    = digit_reg;
        upd_acc      = acc_reg;
        upd_fstate   = fstate_reg;
        if (take)
        begin
            upd_count = count_reg + CNT_W'(1);
            if (count_reg == '0 && char_data.char_code == CHAR_MINUS)
                upd_negative = 1'b1;
            else if (is_digit)
            begin
                upd_digit = 1'b1;
                upd_acc   = acc_times_ten + digit_term;
            end
            else
                upd_nondigit = 1'b1;
            upd_fstate = float_step(char_class(char_data.char_code), fstate_reg);
        end
    end

    // Classification of the finished token
    always_comb
    begin
        result_next.int_value = '0;
        if (upd_digit && !upd_nondigit)
        begin
            result_next.token_class = TOK_INTEGER;
            result_next.int_value   = upd_acc;
        end
        else if (float_enable_reg && float_accept(upd_fstate))
            result_next.token_class = TOK_FLOAT;
        else
            result_next.token_class = TOK_SYMBOL;
    end

    always_comb
    begin
        count_next    = count_reg;
        negative_next = negative_reg;
        nondigit_next = nondigit_reg;
        digit_next    = digit_reg;
        acc_next      = acc_reg;
        fstate_next   = fstate_reg;
        if (char_fire)
        begin
            if (char_data.last)
            begin
                count_next    = '0;
                negative_next = 1'b0;
                nondigit_next = 1'b0;
                digit_next    = 1'b0;
                acc_next      = '0;
                fstate_next   = FS_START;
            end
            else
            begin
                count_next    = upd_count;
                negative_next = upd_negative;
                nondigit_next = upd_nondigit;
                digit_next    = upd_digit;
                acc_next      = upd_acc;
                fstate_next   = upd_fstate;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            negative_reg     <= 1'b0;
            nondigit_reg     <= 1'b0;
            digit_reg        <= 1'b0;
            acc_reg          <= '0;
            fstate_reg       <= FS_START;
            float_enable_reg <= 1'b1;
        end
        else
        begin
            count_reg    <= count_next;
            negative_reg <= negative_next;
            nondigit_reg <= nondigit_next;
            digit_reg    <= digit_next;
            acc_reg      <= acc_next;
            fstate_reg   <= fstate_next;
            if (cfg_write)
                float_enable_reg <= cfg_data;
        end
    end

    // Output register with one skid entry behind it
    assign new_result = char_fire && char_data.last;
    assign out_free   = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= new_result;
        end
        else if (new_result)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (new_result)
                out_data_reg <= result_next;
        end
        else if (new_result)
            skid_data_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

@@ hdl/ntc_checker.sv @@
// Port-level assertions for the number token classifier and the bind that attaches them.
module ntc_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  char_valid,
    input logic                  char_stall,
    input ntc_pkg::char_item_t   char_data,
    input logic                  result_valid,
    input logic                  result_stall,
    input ntc_pkg::result_item_t result_data
);
    import ntc_pkg::*;

    logic last_transfer;

    assign last_transfer = char_valid && !char_stall && char_data.last;

    // A held result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // Only integers carry a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.token_class != TOK_INTEGER |-> result_data.int_value == 64'sd0)
        else $error("non-integer result with nonzero value");

    // After a last-character transfer, result_valid is always high in the next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        last_transfer |=> result_valid)
        else $error("no result after last character");

    // With nothing pending, results appear only after a last-character transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && !last_transfer |=> !result_valid)
        else $error("result without a last character");

endmodule

bind number_token_classifier ntc_checker u_ntc_checker (.*);
